### sv/tone_schedule_stack_assert.svh
// assertion macros for the tone schedule stack
`ifndef TONE_SCHEDULE_STACK_ASSERT_SVH
`define TONE_SCHEDULE_STACK_ASSERT_SVH
`ifndef SYNTHESIS
`define TSS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tone schedule: invariant violated");
`define TSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tone schedule: implication violated");
`define TSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tone schedule: next-cycle check violated");
`else
`define TSS_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define TSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/tss_pkg.sv
// shared types and constants of the tone schedule stack
`default_nettype none

package tss_pkg;

    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] len;
    } t_tone;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_cmd;

    localparam logic        MODE_TICK    = 1'b0;
    localparam logic        MODE_REQ     = 1'b1;
    localparam logic [31:0] GAP_RESET_US = 32'd200000;
    localparam logic [9:0]  US_PER_MS    = 10'd1000;
    localparam int          ADDR_W       = 3;
    localparam logic        REG_GAP_US   = 1'b0;

endpackage

`default_nettype wire

### sv/tss_stack.sv
// shift-register tone stack: entry 0 is always the top
`default_nettype none

module tss_stack #(
    parameter int DEPTH = 6,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  tss_pkg::t_stack_cmd i_cmd,
    input  tss_pkg::t_tone      i_new,
    output logic [CW-1:0]       o_count,
    output logic                o_full,
    output tss_pkg::t_tone      o_top,
    output tss_pkg::t_tone      o_nxt_top,
    output logic [CW-1:0]       o_nxt_count
);

    localparam int SECOND = (DEPTH > 1) ? 1 : 0;

    tss_pkg::t_tone r_ent [DEPTH];
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    tss_pkg::t_tone w_second;

    assign w_second = (DEPTH > 1) ? r_ent[SECOND] : '0;
    assign o_count  = r_count;
    assign o_full   = (r_count == CW'(DEPTH));
    assign o_top    = r_ent[0];

    // view of the stack as it will be after this command
    always_comb begin
        n_count   = r_count;
        o_nxt_top = (r_count != '0) ? r_ent[0] : '0;
        if (i_cmd.push) begin
            n_count   = r_count + CW'(1);
            o_nxt_top = i_new;
        end else if (i_cmd.pop) begin
            n_count   = r_count - CW'(1);
            o_nxt_top = (r_count > CW'(1)) ? w_second : '0;
        end
    end

    assign o_nxt_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // payload entries carry no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_ent[0] <= i_new;
            for (int i = 1; i < DEPTH; i++) begin
                r_ent[i] <= r_ent[i-1];
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_ent[i] <= r_ent[i+1];
            end
        end
    end

endmodule

`default_nettype wire

### sv/tone_schedule_stack.sv
// top level of the tone schedule stack: input stage, sequencing logic, result stage
//
//  channel   direction  handshake                   payload
//  in        sink       i_in_valid / o_in_stall     i_mode i_now_us i_req_freq
//                                                   i_req_duration_ms i_req_regular
//  out       source     o_out_valid / i_out_stall   o_buzzer_on o_tone_start o_tone_freq
//                                                   o_tone_length_ms o_pending_count
//                                                   o_request_dropped
//  cfg       apb slave  psel penable pwrite pready  paddr pwdata prdata
//
// one item per cycle unless the result is stalled; input register, then result register
// the schedule state is updated as an item moves from the input register to the result
// register, so each item sees the state left by the one before it
// synchronous active-low reset clears the schedule, the on/off flag, the time stamp and
// sets gap_us to 200000; stack entries are not cleared
// a stalled result holds the result register; the input register still takes one item
`default_nettype none

`include "tone_schedule_stack_assert.svh"

module tone_schedule_stack #(
    parameter int SCHEDULE_DEPTH = 6
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // input item channel
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire                         i_mode,
    input  wire  [31:0]                 i_now_us,
    input  wire  [15:0]                 i_req_freq,
    input  wire  [15:0]                 i_req_duration_ms,
    input  wire                         i_req_regular,
    // result item channel
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic                        o_buzzer_on,
    output logic                        o_tone_start,
    output logic [15:0]                 o_tone_freq,
    output logic [15:0]                 o_tone_length_ms,
    output logic [2:0]                  o_pending_count,
    output logic                        o_request_dropped,
    // configuration port
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [tss_pkg::ADDR_W-1:0]  paddr,
    input  wire  [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int CW = $clog2(SCHEDULE_DEPTH + 1);

    // configuration
    logic [31:0] r_gap_us;
    logic        w_cfg_wr;
    logic        w_sel_gap;

    assign pready    = 1'b1;
    assign w_sel_gap = (paddr[2] == tss_pkg::REG_GAP_US);
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign prdata    = w_sel_gap ? r_gap_us : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_us <= tss_pkg::GAP_RESET_US;
        end else if (w_cfg_wr && w_sel_gap) begin
            r_gap_us <= pwdata;
        end
    end

    // input register
    logic        r_s1_valid;
    logic        r_s1_mode;
    logic [31:0] r_s1_now;
    logic [15:0] r_s1_freq;
    logic [15:0] r_s1_dur;
    logic        r_s1_regular;
    logic        w_accept;
    logic        w_advance;
    logic        w_out_block;

    // the result register blocks only while it holds an item that is stalled
    assign w_out_block = o_out_valid && i_out_stall;
    assign w_advance   = r_s1_valid && !w_out_block;
    assign o_in_stall  = r_s1_valid && w_out_block;
    assign w_accept    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_mode    <= i_mode;
            r_s1_now     <= i_now_us;
            r_s1_freq    <= i_req_freq;
            r_s1_dur     <= i_req_duration_ms;
            r_s1_regular <= i_req_regular;
        end
    end

    // schedule
    tss_pkg::t_stack_cmd w_cmd;
    tss_pkg::t_tone      w_new;
    tss_pkg::t_tone      w_top;
    tss_pkg::t_tone      w_nxt_top;
    logic [CW-1:0]       w_count;
    logic [CW-1:0]       w_nxt_count;
    logic                w_full;

    assign w_new.freq = r_s1_freq;
    assign w_new.len  = r_s1_dur;

    tss_stack #(
        .DEPTH (SCHEDULE_DEPTH),
        .CW    (CW)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_new       (w_new),
        .o_count     (w_count),
        .o_full      (w_full),
        .o_top       (w_top),
        .o_nxt_top   (w_nxt_top),
        .o_nxt_count (w_nxt_count)
    );

    // sequencing state
    logic        r_sounding;
    logic [31:0] r_last_us;
    logic        w_is_req;
    logic        w_pending;
    logic        w_push;
    logic        w_dropped;
    logic        w_tick;
    logic [31:0] w_elapsed;
    logic [25:0] w_limit;
    logic        w_start;
    logic        w_stop;
    logic        n_sounding;

    assign w_is_req  = (r_s1_mode == tss_pkg::MODE_REQ);
    assign w_pending = (w_count != '0);

    // a regular request yields to pending tones; any push onto a full schedule is dropped
    assign w_push    = w_is_req && !(r_s1_regular && w_pending) && !w_full;
    assign w_dropped = w_is_req && !w_push;

    // ticks only matter while something is scheduled
    assign w_tick    = (r_s1_mode == tss_pkg::MODE_TICK) && w_pending;
    assign w_elapsed = r_s1_now - r_last_us;
    assign w_limit   = {10'd0, w_top.len} * {16'd0, tss_pkg::US_PER_MS};

    // silent long enough: start the top tone; sounding past its length: end and pop it
    assign w_start   = w_tick && !r_sounding && (w_elapsed > r_gap_us);
    assign w_stop    = w_tick && r_sounding && (w_elapsed > {6'd0, w_limit});

    assign w_cmd.push = w_advance && w_push;
    assign w_cmd.pop  = w_advance && w_stop;

    always_comb begin
        n_sounding = r_sounding;
        if (w_start) begin
            n_sounding = 1'b1;
        end else if (w_stop) begin
            n_sounding = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sounding <= 1'b0;
            r_last_us  <= '0;
        end else if (w_advance) begin
            r_sounding <= n_sounding;
            if (w_start || w_stop) begin
                r_last_us <= r_s1_now;
            end
        end
    end

    // result register
    logic [CW+2:0] w_count_ext;
    logic          r_out_valid;
    logic          r_buzzer_on;
    logic          r_tone_start;
    logic [15:0]   r_tone_freq;
    logic [15:0]   r_tone_len;
    logic [2:0]    r_pending;
    logic          r_dropped;

    // count reported modulo 8
    assign w_count_ext = {3'd0, w_nxt_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_buzzer_on  <= n_sounding;
            r_tone_start <= w_start;
            r_tone_freq  <= w_nxt_top.freq;
            r_tone_len   <= w_nxt_top.len;
            r_pending    <= w_count_ext[2:0];
            r_dropped    <= w_dropped;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_buzzer_on       = r_buzzer_on;
    assign o_tone_start      = r_tone_start;
    assign o_tone_freq       = r_tone_freq;
    assign o_tone_length_ms  = r_tone_len;
    assign o_pending_count   = r_pending;
    assign o_request_dropped = r_dropped;

    // checks
    `TSS_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, w_count <= CW'(SCHEDULE_DEPTH))
    `TSS_ASSERT_IMPL(a_sound_has_tone, i_clk, i_rst_n, r_sounding, w_count != '0)
    `TSS_ASSERT_IMPL(a_start_is_on, i_clk, i_rst_n, o_out_valid && o_tone_start, o_buzzer_on)
    `TSS_ASSERT_NEXT(a_stamp_on_start, i_clk, i_rst_n, w_advance && w_start, r_last_us == $past(r_s1_now))

endmodule

`default_nettype wire
